@@ src/pac_pkg.sv @@
// Shared types, constants and the arctangent table for the pursuit arc curvature core.
package pac_pkg;

   localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
   localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
   localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
   localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

   localparam int REM_W = 63;
   localparam int DEN_W = 62;
   localparam int MAG_W = 63;
   localparam int QUO_W = 32;

   typedef logic [1:0] pac_status_type;
   localparam pac_status_type STATUS_OK    = 2'd0;
   localparam pac_status_type STATUS_COINC = 2'd1;
   localparam pac_status_type STATUS_SAT   = 2'd2;

   typedef struct packed {
      logic               coinc;
      logic [1:0]         k;
      logic signed [30:0] dx;
      logic signed [30:0] dy;
   } pac_side_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ src/pac_front.sv @@
// Front end: deltas, delta scaling, heading wrap and fold into the CORDIC range.
module pac_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [31:0]   start_x,
   input  logic signed [31:0]   start_y,
   input  logic signed [31:0]   heading,
   input  logic signed [31:0]   goal_x,
   input  logic signed [31:0]   goal_y,
   output logic                 out_valid,
   output pac_pkg::pac_side_type out_side,
   output logic signed [33:0]   out_z,
   output logic                 out_flip
);
   import pac_pkg::*;

   logic               v1_ff, v2_ff;
   logic signed [32:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [31:0] h_ff, h_in;
   logic signed [32:0] hw;

   pac_side_type       side_ff, side_in;
   logic signed [33:0] z_ff, z_in;
   logic               flip_ff, flip_in;

   logic [32:0]        mx, my, m;
   logic [1:0]         k;
   logic signed [32:0] bx, by, sx, sy, hf;

   always_comb begin
      dx_in = 33'(goal_x) - 33'(start_x);
      dy_in = 33'(goal_y) - 33'(start_y);
      hw    = 33'(heading);
      if (hw > PI_Q28) begin
         hw = hw - TWO_PI_Q28;
      end else if (hw < -PI_Q28) begin
         hw = hw + TWO_PI_Q28;
      end
      h_in = 32'(hw);
   end

   always_comb begin
      mx = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      my = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      m  = (mx > my) ? mx : my;
      if (m < 33'h040000000) begin
         k = 2'd0;
      end else if (m < 33'h080000000) begin
         k = 2'd1;
      end else if (m < 33'h100000000) begin
         k = 2'd2;
      end else begin
         k = 2'd3;
      end
      // truncate toward zero
      bx = dx_ff[32] ? ((33'sd1 <<< k) - 33'sd1) : 33'sd0;
      by = dy_ff[32] ? ((33'sd1 <<< k) - 33'sd1) : 33'sd0;
      sx = (dx_ff + bx) >>> k;
      sy = (dy_ff + by) >>> k;
      side_in.coinc = (dx_ff == 33'sd0) && (dy_ff == 33'sd0);
      side_in.k     = k;
      side_in.dx    = 31'(sx);
      side_in.dy    = 31'(sy);

      hf      = 33'(h_ff);
      flip_in = 1'b0;
      if (hf > HALF_PI_Q28) begin
         hf      = hf - PI_Q28;
         flip_in = 1'b1;
      end else if (hf < -HALF_PI_Q28) begin
         hf      = hf + PI_Q28;
         flip_in = 1'b1;
      end
      z_in = 34'(hf <<< 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      h_ff    <= h_in;
      side_ff <= side_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign out_valid = v2_ff;
   assign out_side  = side_ff;
   assign out_z     = z_ff;
   assign out_flip  = flip_ff;

endmodule

@@ src/pac_cordic.sv @@
// Rotation-mode CORDIC, one register stage per iteration.
module pac_cordic #(
   parameter int STAGES = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  pac_pkg::pac_side_type in_side,
   input  logic signed [33:0]   in_z,
   input  logic                 in_flip,
   output logic                 out_valid,
   output pac_pkg::pac_side_type out_side,
   output logic signed [33:0]   out_x,
   output logic signed [33:0]   out_y,
   output logic                 out_flip
);
   import pac_pkg::*;

   logic               v_ff    [STAGES];
   logic signed [33:0] x_ff    [STAGES];
   logic signed [33:0] y_ff    [STAGES];
   logic signed [33:0] z_ff    [STAGES];
   logic               flip_ff [STAGES];
   pac_side_type       side_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic signed [33:0] xi, yi, zi, x_in, y_in, z_in, ang;
      logic               vi, fi;
      pac_side_type       si;

      if (g == 0) begin : g_first
         assign xi = CORDIC_K_Q30;
         assign yi = '0;
         assign zi = in_z;
         assign vi = in_valid;
         assign fi = in_flip;
         assign si = in_side;
      end else begin : g_next
         assign xi = x_ff[g-1];
         assign yi = y_ff[g-1];
         assign zi = z_ff[g-1];
         assign vi = v_ff[g-1];
         assign fi = flip_ff[g-1];
         assign si = side_ff[g-1];
      end

      always_comb begin
         ang = 34'(atan_q30(5'(g)));
         if (zi >= 34'sd0) begin
            x_in = xi - (yi >>> g);
            y_in = yi + (xi >>> g);
            z_in = zi - ang;
         end else begin
            x_in = xi + (yi >>> g);
            y_in = yi - (xi >>> g);
            z_in = zi + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else begin
            v_ff[g] <= vi;
         end
         x_ff[g]    <= x_in;
         y_ff[g]    <= y_in;
         z_ff[g]    <= z_in;
         flip_ff[g] <= fi;
         side_ff[g] <= si;
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
   assign out_x     = x_ff[STAGES-1];
   assign out_y     = y_ff[STAGES-1];
   assign out_flip  = flip_ff[STAGES-1];

endmodule

@@ src/pac_arith.sv @@
// Cross product, squared distance and dividend alignment.
module pac_arith #(
   parameter int FRAC_BITS = 16,
   localparam int E0   = 2 * FRAC_BITS - 29,
   localparam int EMAX = (E0 > 0) ? E0 : 0,
   localparam int NW   = 63 + EMAX
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  pac_pkg::pac_side_type     in_side,
   input  logic signed [33:0]        in_x,
   input  logic signed [33:0]        in_y,
   input  logic                      in_flip,
   output logic                      out_valid,
   output logic [NW-1:0]             out_num,
   output logic [pac_pkg::DEN_W-1:0] out_den,
   output logic                      out_neg,
   output logic                      out_coinc
);
   import pac_pkg::*;

   logic               va_ff, vb_ff, vc_ff;
   logic signed [31:0] sn, cs;
   logic signed [63:0] p1_ff, p2_ff, p3_ff, p4_ff, p1_in, p2_in, p3_in, p4_in;
   logic               ca_ff, cb_ff, cc_ff;
   logic [1:0]         ka_ff, kb_ff;

   logic signed [64:0] s;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [DEN_W-1:0]   d2_ff, d2_in, dc_ff;
   logic               nb_ff, nb_in, nc_ff;

   logic signed [7:0]  e_sh, e_neg;
   logic [NW-1:0]      n_ff, n_in;

   always_comb begin
      sn    = in_flip ? 32'(-in_y) : 32'(in_y);
      cs    = in_flip ? 32'(-in_x) : 32'(in_x);
      p1_in = sn * in_side.dx;
      p2_in = cs * in_side.dy;
      p3_in = in_side.dx * in_side.dx;
      p4_in = in_side.dy * in_side.dy;
   end

   always_comb begin
      s      = 65'(p1_ff) - 65'(p2_ff);
      d2_in  = DEN_W'(p3_ff) + DEN_W'(p4_ff);
      nb_in  = s[64];
      mag_in = nb_in ? MAG_W'(-s) : MAG_W'(s);
   end

   always_comb begin
      e_sh  = 8'(E0) - 8'({6'd0, kb_ff});
      e_neg = -e_sh;
      if (!e_sh[7]) begin
         n_in = NW'(mag_ff) << e_sh[4:0];
      end else begin
         n_in = NW'(mag_ff) >> e_neg[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      p3_ff  <= p3_in;
      p4_ff  <= p4_in;
      ca_ff  <= in_side.coinc;
      ka_ff  <= in_side.k;
      mag_ff <= mag_in;
      d2_ff  <= d2_in;
      nb_ff  <= nb_in;
      cb_ff  <= ca_ff;
      kb_ff  <= ka_ff;
      n_ff   <= n_in;
      dc_ff  <= d2_ff;
      nc_ff  <= nb_ff;
      cc_ff  <= cb_ff;
   end

   assign out_valid = vc_ff;
   assign out_num   = n_ff;
   assign out_den   = dc_ff;
   assign out_neg   = nc_ff;
   assign out_coinc = cc_ff;

endmodule

@@ src/pac_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with saturation and result register.
module pac_divider #(
   parameter int FRAC_BITS = 16,
   localparam int E0   = 2 * FRAC_BITS - 29,
   localparam int EMAX = (E0 > 0) ? E0 : 0,
   localparam int NW   = 63 + EMAX
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [NW-1:0]             in_num,
   input  logic [pac_pkg::DEN_W-1:0] in_den,
   input  logic                      in_neg,
   input  logic                      in_coinc,
   output logic                      out_valid,
   output logic signed [31:0]        out_curvature,
   output pac_pkg::pac_status_type   out_status
);
   import pac_pkg::*;

   localparam int NS = QUO_W + 1;

   logic             v_ff    [NS];
   logic [REM_W-1:0] rem_ff  [NS];
   logic [QUO_W-1:0] lo_ff   [NS];
   logic [QUO_W-1:0] q_ff    [NS];
   logic [DEN_W-1:0] den_ff  [NS];
   logic             neg_ff  [NS];
   logic             co_ff   [NS];
   logic             ovf_ff  [NS];

   logic [REM_W-1:0] hi_in;
   logic             ovf_in;

   logic                rv_ff;
   logic signed [31:0]  cur_ff, cur_in;
   pac_status_type      st_ff, st_in;
   logic [QUO_W-1:0]    qf, lim;
   logic                sat;

   always_comb begin
      hi_in  = REM_W'(in_num >> QUO_W);
      ovf_in = hi_in >= REM_W'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      rem_ff[0] <= hi_in;
      lo_ff[0]  <= in_num[QUO_W-1:0];
      q_ff[0]   <= '0;
      den_ff[0] <= in_den;
      neg_ff[0] <= in_neg;
      co_ff[0]  <= in_coinc;
      ovf_ff[0] <= ovf_in;
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_bit
      logic [REM_W-1:0] t, r_in;
      logic             ge;

      always_comb begin
         t    = {rem_ff[g][REM_W-2:0], lo_ff[g][QUO_W-1]};
         ge   = t >= REM_W'(den_ff[g]);
         r_in = ge ? (t - REM_W'(den_ff[g])) : t;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else begin
            v_ff[g+1] <= v_ff[g];
         end
         rem_ff[g+1] <= r_in;
         lo_ff[g+1]  <= {lo_ff[g][QUO_W-2:0], 1'b0};
         q_ff[g+1]   <= {q_ff[g][QUO_W-2:0], ge};
         den_ff[g+1] <= den_ff[g];
         neg_ff[g+1] <= neg_ff[g];
         co_ff[g+1]  <= co_ff[g];
         ovf_ff[g+1] <= ovf_ff[g];
      end
   end

   always_comb begin
      qf  = q_ff[QUO_W];
      lim = neg_ff[QUO_W] ? 32'h80000000 : 32'h7FFFFFFF;
      sat = ovf_ff[QUO_W] || (qf > lim);
      if (co_ff[QUO_W]) begin
         cur_in = '0;
         st_in  = STATUS_COINC;
      end else if (sat) begin
         cur_in = neg_ff[QUO_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
         st_in  = STATUS_SAT;
      end else begin
         cur_in = neg_ff[QUO_W] ? 32'(-qf) : 32'(qf);
         st_in  = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= v_ff[QUO_W];
      end
      cur_ff <= cur_in;
      st_ff  <= st_in;
   end

   assign out_valid     = rv_ff;
   assign out_curvature = cur_ff;
   assign out_status    = st_ff;

endmodule

@@ src/pursuit_arc_curvature_core.sv @@
// Top level of the pursuit arc curvature core.
// Fully pipelined: one item may be started every cycle and busy stays low. Each item's result
// appears on rsp_* with rsp_valid high for one cycle, in start order, after it passes through
// two front stages, one per CORDIC iteration, three multiply and alignment stages, and 34
// stages in the bit-per-stage divider. The receiver cannot stall, so results must be taken
// as they come. Status 1 flags coincident points (curvature zero), status 2 a saturated
// curvature.
module pursuit_arc_curvature_core #(
   parameter int CORDIC_STAGES   = 24,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [31:0]      req_start_x,
   input  logic signed [31:0]      req_start_y,
   input  logic signed [31:0]      req_heading,
   input  logic signed [31:0]      req_goal_x,
   input  logic signed [31:0]      req_goal_y,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_curvature,
   output pac_pkg::pac_status_type rsp_status
);
   import pac_pkg::*;

   localparam int E0   = 2 * COORD_FRAC_BITS - 29;
   localparam int EMAX = (E0 > 0) ? E0 : 0;
   localparam int NW   = 63 + EMAX;

   logic               f_valid, c_valid, a_valid;
   pac_side_type       f_side, c_side;
   logic signed [33:0] f_z, c_x, c_y;
   logic               f_flip, c_flip;
   logic [NW-1:0]      a_num;
   logic [DEN_W-1:0]   a_den;
   logic               a_neg, a_coinc;

   assign busy = 1'b0;

   pac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .heading   (req_heading),
      .goal_x    (req_goal_x),
      .goal_y    (req_goal_y),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_z     (f_z),
      .out_flip  (f_flip)
   );

   pac_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_z      (f_z),
      .in_flip   (f_flip),
      .out_valid (c_valid),
      .out_side  (c_side),
      .out_x     (c_x),
      .out_y     (c_y),
      .out_flip  (c_flip)
   );

   pac_arith #(.FRAC_BITS(COORD_FRAC_BITS)) u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_side   (c_side),
      .in_x      (c_x),
      .in_y      (c_y),
      .in_flip   (c_flip),
      .out_valid (a_valid),
      .out_num   (a_num),
      .out_den   (a_den),
      .out_neg   (a_neg),
      .out_coinc (a_coinc)
   );

   pac_divider #(.FRAC_BITS(COORD_FRAC_BITS)) u_divider (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (a_valid),
      .in_num        (a_num),
      .in_den        (a_den),
      .in_neg        (a_neg),
      .in_coinc      (a_coinc),
      .out_valid     (rsp_valid),
      .out_curvature (rsp_curvature),
      .out_status    (rsp_status)
   );

endmodule

@@ src/pac_checker.sv @@
// Port-level checks for the pursuit arc curvature core, bound to the top level.
module pac_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic signed [31:0]      rsp_curvature,
   input pac_pkg::pac_status_type rsp_status
);
   import pac_pkg::*;

   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("item delivered straight after reset");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_COINC ||
                     rsp_status == STATUS_SAT))
      else $error("undefined status code");

   a_coinc_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_COINC) |-> (rsp_curvature == 32'sd0))
      else $error("coincident item with nonzero curvature");

   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_SAT) |->
         (rsp_curvature == 32'sh7FFFFFFF || rsp_curvature == 32'sh80000000))
      else $error("saturated item not at a limit");

   a_never_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> !busy)
      else $error("busy raised after start");

endmodule

bind pursuit_arc_curvature_core pac_checker u_pac_checker (.*);
